// ===== design/skeleton_joint_global_transform_defines.svh =====
// assertion macros for the skeleton joint global transform
// used by the top level only, no other dependencies
`ifndef SKELETON_JOINT_GLOBAL_TRANSFORM_DEFINES_SVH
`define SKELETON_JOINT_GLOBAL_TRANSFORM_DEFINES_SVH

// same-cycle implication, held off during reset
`define SJGT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sjgt check failed");

// next-cycle implication, held off during reset
`define SJGT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sjgt check failed");

`endif

// ===== design/sjgt_pkg.sv =====
// shared types, constants and rounding helper for the joint transform block
// no dependencies
package sjgt_pkg;

  localparam int MAX_JOINTS_DEF = 256;
  localparam int IN_W  = 152;
  localparam int OUT_W = 240;

  typedef enum logic [2:0] {
    ST_IDLE, ST_FETCH, ST_LOC, ST_MAC, ST_DRAIN, ST_OUT, ST_WRITE
  } sjgt_state_t;

  typedef struct packed {
    logic       load;
    logic       fetch_en;
    logic [3:0] idx;
    logic       loc_en;
    logic       mac_en;
    logic [1:0] mi;
    logic [1:0] mj;
    logic [1:0] mk;
    logic       out_load;
    logic       wr_en;
  } sjgt_cmd_t;

  // shift right 15 rounding half up, saturate to q1.15
  function automatic logic signed [15:0] q15_sat(input logic signed [43:0] v);
    logic signed [43:0] t;
    logic signed [28:0] s;
    t = v + 44'sd16384;
    s = t[43:15];
    if (s > 29'sd32767) return 16'sd32767;
    if (s < -29'sd32768) return -16'sd32768;
    return s[15:0];
  endfunction

endpackage

// ===== design/sjgt_datapath.sv =====
// datapath: quaternion products, local rotation, shared mac and joint stores
// depends on sjgt_pkg
module sjgt_datapath #(
  parameter int MAX_JOINTS = sjgt_pkg::MAX_JOINTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [sjgt_pkg::IN_W-1:0]  in_data,
  input  sjgt_pkg::sjgt_cmd_t        cmd,
  output logic [sjgt_pkg::OUT_W-1:0] out_data
);
  import sjgt_pkg::*;

  localparam int AW = $clog2(MAX_JOINTS * 9);
  localparam int TW = $clog2(MAX_JOINTS * 3);

  logic signed [15:0] rmem [MAX_JOINTS*9];
  logic signed [31:0] tmem [MAX_JOINTS*3];

  logic [7:0]         joint_r, parent_r;
  logic signed [15:0] qw_r, qx_r, qy_r, qz_r;
  logic signed [23:0] t_r [3];
  logic               root_r, store_r;
  logic signed [31:0] qp_r [9];
  logic signed [15:0] loc_r [9];
  logic signed [15:0] pr_r [9];
  logic signed [31:0] pt_r [3];
  logic signed [15:0] gr_r [9];
  logic signed [31:0] gt_r [3];
  logic signed [15:0] rq_r;
  logic signed [31:0] tq_r;
  logic               cap_en_r;
  logic [3:0]         cap_idx_r;
  logic signed [39:0] prod_r;
  logic               tag_v_r;
  logic [1:0]         ti_r, tj_r, tk_r;
  logic signed [41:0] acc_r;
  logic [OUT_W-1:0]   out_r;

  logic [31:0]        rd_base, wr_base, rd_tb, wr_tb;
  logic [AW-1:0]      raddr, waddr;
  logic [TW-1:0]      taddr, twaddr;
  logic signed [15:0] qa, qb;
  logic signed [35:0] le [9];
  logic signed [15:0] ma;
  logic signed [23:0] mb;
  logic signed [41:0] sum;
  logic signed [41:0] tr;
  logic signed [33:0] tsum;
  logic signed [31:0] tsat;
  logic signed [15:0] res_rot [9];
  logic signed [31:0] res_t [3];
  logic signed [35:0] one_q;

  assign rd_base = 32'(parent_r) * 32'd9 + 32'(cmd.idx);
  assign wr_base = 32'(joint_r) * 32'd9 + 32'(cmd.idx);
  assign rd_tb   = 32'(parent_r) * 32'd3 + 32'(cmd.idx);
  assign wr_tb   = 32'(joint_r) * 32'd3 + 32'(cmd.idx);
  assign raddr   = rd_base[AW-1:0];
  assign waddr   = wr_base[AW-1:0];
  assign taddr   = rd_tb[TW-1:0];
  assign twaddr  = wr_tb[TW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      joint_r  <= in_data[7:0];
      parent_r <= in_data[15:8];
      qw_r     <= in_data[31:16];
      qx_r     <= in_data[47:32];
      qy_r     <= in_data[63:48];
      qz_r     <= in_data[79:64];
      t_r[0]   <= in_data[103:80];
      t_r[1]   <= in_data[127:104];
      t_r[2]   <= in_data[151:128];
      root_r   <= (in_data[7:0] == 8'd0) || (32'(in_data[15:8]) >= MAX_JOINTS);
      store_r  <= 32'(in_data[7:0]) < MAX_JOINTS;
    end
  end

  // quaternion pair products, one per fetch step
  always_comb begin
    case (cmd.idx)
      4'd0:    begin qa = qx_r; qb = qx_r; end
      4'd1:    begin qa = qy_r; qb = qy_r; end
      4'd2:    begin qa = qz_r; qb = qz_r; end
      4'd3:    begin qa = qx_r; qb = qy_r; end
      4'd4:    begin qa = qx_r; qb = qz_r; end
      4'd5:    begin qa = qy_r; qb = qz_r; end
      4'd6:    begin qa = qw_r; qb = qx_r; end
      4'd7:    begin qa = qw_r; qb = qy_r; end
      default: begin qa = qw_r; qb = qz_r; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch_en) begin
      qp_r[cmd.idx] <= qa * qb;
    end
  end

  // parent fetch, registered read then capture
  always_ff @(posedge clk) begin
    rq_r <= rmem[raddr];
    tq_r <= tmem[taddr];
    if (cmd.wr_en && store_r) begin
      rmem[waddr] <= res_rot[cmd.idx];
      if (cmd.idx < 4'd3) tmem[twaddr] <= res_t[cmd.idx[1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_en_r <= 1'b0;
      tag_v_r  <= 1'b0;
    end else begin
      cap_en_r <= cmd.fetch_en;
      tag_v_r  <= cmd.mac_en;
    end
    cap_idx_r <= cmd.idx;
    if (cap_en_r) begin
      pr_r[cap_idx_r] <= rq_r;
      if (cap_idx_r < 4'd3) pt_r[cap_idx_r[1:0]] <= tq_r;
    end
  end

  // local rotation from the products, exact in q6.30
  assign one_q = 36'sd1073741824;
  always_comb begin
    le[0] = one_q - 36'sd2 * (36'(qp_r[1]) + 36'(qp_r[2]));
    le[1] = 36'sd2 * (36'(qp_r[3]) - 36'(qp_r[8]));
    le[2] = 36'sd2 * (36'(qp_r[4]) + 36'(qp_r[7]));
    le[3] = 36'sd2 * (36'(qp_r[3]) + 36'(qp_r[8]));
    le[4] = one_q - 36'sd2 * (36'(qp_r[0]) + 36'(qp_r[2]));
    le[5] = 36'sd2 * (36'(qp_r[5]) - 36'(qp_r[6]));
    le[6] = 36'sd2 * (36'(qp_r[4]) - 36'(qp_r[7]));
    le[7] = 36'sd2 * (36'(qp_r[5]) + 36'(qp_r[6]));
    le[8] = one_q - 36'sd2 * (36'(qp_r[0]) + 36'(qp_r[1]));
  end

  always_ff @(posedge clk) begin
    if (cmd.loc_en) begin
      for (int n = 0; n < 9; n++) loc_r[n] <= q15_sat(44'(le[n]));
    end
  end

  // shared multiply-accumulate, column three is the translation
  always_comb begin
    ma = pr_r[4'(cmd.mi) * 4'd3 + 4'(cmd.mk)];
    if (cmd.mj == 2'd3) mb = t_r[cmd.mk];
    else mb = 24'(loc_r[4'(cmd.mk) * 4'd3 + 4'(cmd.mj)]);
  end

  assign sum  = ((tk_r == 2'd0) ? 42'sd0 : acc_r) + 42'(prod_r);
  assign tr   = sum + 42'sd16384;
  assign tsum = 34'($signed(tr[41:15])) + 34'(pt_r[ti_r]);
  always_comb begin
    if (tsum > 34'sd2147483647) tsat = 32'sh7fffffff;
    else if (tsum < -34'sd2147483648) tsat = 32'sh80000000;
    else tsat = tsum[31:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.mac_en) begin
      prod_r <= ma * mb;
      ti_r   <= cmd.mi;
      tj_r   <= cmd.mj;
      tk_r   <= cmd.mk;
    end
    if (tag_v_r) begin
      acc_r <= sum;
      if (tk_r == 2'd2) begin
        if (tj_r == 2'd3) gt_r[ti_r] <= tsat;
        else gr_r[4'(ti_r) * 4'd3 + 4'(tj_r)] <= q15_sat(44'(sum));
      end
    end
  end

  always_comb begin
    for (int n = 0; n < 9; n++) res_rot[n] = root_r ? loc_r[n] : gr_r[n];
    for (int n = 0; n < 3; n++) res_t[n] = root_r ? 32'(t_r[n]) : gt_r[n];
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r <= {res_t[2], res_t[1], res_t[0], res_rot[8], res_rot[7], res_rot[6],
                res_rot[5], res_rot[4], res_rot[3], res_rot[2], res_rot[1], res_rot[0]};
    end
  end

  assign out_data = out_r;

endmodule

// ===== design/sjgt_ctrl.sv =====
// controller: sequences fetch, local rotation, mac, output and store write
// depends on sjgt_pkg
module sjgt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  output sjgt_pkg::sjgt_cmd_t cmd
);
  import sjgt_pkg::*;

  sjgt_state_t state_r, state_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [1:0]  mi_r, mi_nxt, mj_r, mj_nxt, mk_r, mk_nxt;
  logic        out_vld_r, out_vld_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= 4'd0;
      mi_r      <= 2'd0;
      mj_r      <= 2'd0;
      mk_r      <= 2'd0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      mi_r      <= mi_nxt;
      mj_r      <= mj_nxt;
      mk_r      <= mk_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    mi_nxt    = mi_r;
    mj_nxt    = mj_r;
    mk_nxt    = mk_r;
    in_tready = 1'b0;
    cmd       = '0;
    cmd.idx   = cnt_r;
    cmd.mi    = mi_r;
    cmd.mj    = mj_r;
    cmd.mk    = mk_r;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = 4'd0;
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        cmd.fetch_en = 1'b1;
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd8) state_nxt = ST_LOC;
      end
      ST_LOC: begin
        cmd.loc_en = 1'b1;
        mi_nxt = 2'd0;
        mj_nxt = 2'd0;
        mk_nxt = 2'd0;
        state_nxt = ST_MAC;
      end
      ST_MAC: begin
        cmd.mac_en = 1'b1;
        mk_nxt = mk_r + 2'd1;
        if (mk_r == 2'd2) begin
          mk_nxt = 2'd0;
          mj_nxt = mj_r + 2'd1;
          if (mj_r == 2'd3) mi_nxt = mi_r + 2'd1;
          if (mj_r == 2'd3 && mi_r == 2'd2) begin
            cnt_nxt   = 4'd0;
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd1) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_vld_r || out_tready) begin
          cmd.out_load = 1'b1;
          cnt_nxt   = 4'd0;
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd.wr_en = 1'b1;
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd8) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // result beat slot, refilled only once the previous beat has gone
  always_comb begin
    if (cmd.out_load) out_vld_nxt = 1'b1;
    else if (out_tready) out_vld_nxt = 1'b0;
    else out_vld_nxt = out_vld_r;
  end

  assign out_tvalid = out_vld_r;

endmodule

// ===== design/skeleton_joint_global_transform.sv =====
// Skeleton joint global transform: one joint per input beat, one result beat
// per joint. Each joint runs through a sequence of steps from acceptance until
// it is ready for the next, so a new joint is taken only once the previous
// one is through: quaternion products overlapped with the parent fetch from
// the joint stores, forming the local rotation, the single shared 16x24
// multiply-accumulate (three products per matrix entry), pipeline drain,
// loading the result register and writing the nine rotation entries and
// three translation entries through the stores' single write ports. A result
// beat that is not taken holds the sequence before the write. The stores need
// no clearing after reset; a parent must be sent before its children.
// depends on sjgt_pkg, sjgt_ctrl, sjgt_datapath and the defines header
`include "skeleton_joint_global_transform_defines.svh"

module skeleton_joint_global_transform #(
  parameter int MAX_JOINTS = sjgt_pkg::MAX_JOINTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // joint_index, parent_index, quat_w, quat_x, quat_y, quat_z,
  // local_tx, local_ty, local_tz
  input  logic [sjgt_pkg::IN_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // rot_00, rot_01, rot_02, rot_10, rot_11, rot_12, rot_20, rot_21, rot_22,
  // global_tx, global_ty, global_tz
  output logic [sjgt_pkg::OUT_W-1:0] out_tdata
);
  import sjgt_pkg::*;

  sjgt_cmd_t cmd;

  sjgt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  sjgt_datapath #(.MAX_JOINTS(MAX_JOINTS)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_tdata),
    .cmd      (cmd),
    .out_data (out_tdata)
  );

  `SJGT_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)
  `SJGT_ASSERT_NOW(a_no_overwrite, out_tvalid && !out_tready, !cmd.out_load)
  `SJGT_ASSERT_NOW(a_idle_no_work, in_tready, !cmd.mac_en && !cmd.wr_en && !cmd.fetch_en)

endmodule
